/* src/stx_etx_xor_frame_receiver_top_macros.svh */
// Assertion macros for the frame receiver
`ifndef STX_ETX_XOR_FRAME_RECEIVER_TOP_MACROS_SVH
`define STX_ETX_XOR_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define STX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/stx_pkg.sv */
// Shared types, constants and helpers for the frame receiver
package stx_pkg;

  localparam int CNT_W = 32;
  localparam int LEN_W = 13;
  localparam int OUT_CNT_W = 32;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [4:0] LEN_HIGH_MASK = 5'h1F;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(255);
  localparam logic [7:0] APP_ID_RESET = 8'h00;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_ETX_ERR  = 2'd2,
    KIND_CSUM_ERR = 2'd3
  } kind_t;

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_APP_ID  = 1'b1;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] csum_err_total;
    logic [OUT_CNT_W-1:0] err_total;
    logic [OUT_CNT_W-1:0] pkt_total;
    logic [7:0]           data;
    kind_t                kind;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage

/* src/stx_parser.sv */
// Per-byte frame parser: phase, running XOR, length and saturating counters
module stx_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  input  logic [stx_pkg::LEN_W-1:0] max_len,
  input  logic [7:0]           app_id,
  output logic                 res_valid,
  output stx_pkg::result_t     res
);
  import stx_pkg::*;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_ID      = 7'b0000010,
    PH_LEN_HI  = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CHECK   = 7'b0100000,
    PH_ETX     = 7'b1000000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         frame_id_r, frame_id_nxt;
  logic [4:0]         len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]   left_r, left_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic [7:0]         check_r, check_nxt;
  logic [CNT_W-1:0]   pkt_r, pkt_nxt;
  logic [CNT_W-1:0]   err_r, err_nxt;
  logic [CNT_W-1:0]   csum_r, csum_nxt;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   left_dec;
  kind_t              kind;
  logic [7:0]         data;

  assign len      = {len_hi_r, rx_byte};
  assign left_dec = left_r - 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    frame_id_nxt = frame_id_r;
    len_hi_nxt   = len_hi_r;
    left_nxt     = left_r;
    xor_nxt      = xor_r;
    check_nxt    = check_r;
    pkt_nxt      = pkt_r;
    err_nxt      = err_r;
    csum_nxt     = csum_r;
    res_valid    = 1'b0;
    kind         = KIND_PAYLOAD;
    data         = 8'h00;
    if (fire) begin
      unique case (phase_r)
        PH_ID: begin
          frame_id_nxt = rx_byte;
          xor_nxt      = rx_byte;
          phase_nxt    = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_nxt = rx_byte[4:0] & LEN_HIGH_MASK;
          xor_nxt    = xor_r ^ rx_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          xor_nxt = xor_r ^ rx_byte;
          if (len > max_len) begin
            phase_nxt = PH_HUNT;
          end else begin
            pkt_nxt = sat_inc(pkt_r);
            if (frame_id_r != app_id) begin
              phase_nxt = PH_HUNT;
            end else begin
              left_nxt  = len;
              phase_nxt = (len == '0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          xor_nxt   = xor_r ^ rx_byte;
          left_nxt  = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_CHECK;
          end
          res_valid = 1'b1;
          kind      = KIND_PAYLOAD;
          data      = rx_byte;
        end
        PH_CHECK: begin
          check_nxt = rx_byte;
          phase_nxt = PH_ETX;
        end
        PH_ETX: begin
          phase_nxt = PH_HUNT;
          res_valid = 1'b1;
          priority if (rx_byte != ETX_BYTE) begin
            err_nxt = sat_inc(err_r);
            kind    = KIND_ETX_ERR;
          end else if (xor_r != check_r) begin
            err_nxt  = sat_inc(err_r);
            csum_nxt = sat_inc(csum_r);
            kind     = KIND_CSUM_ERR;
          end else begin
            kind = KIND_GOOD;
          end
        end
        default: begin
          phase_nxt = (rx_byte == STX_BYTE) ? PH_ID : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    res.kind           = kind;
    res.data           = data;
    res.pkt_total      = OUT_CNT_W'(pkt_nxt);
    res.err_total      = OUT_CNT_W'(err_nxt);
    res.csum_err_total = OUT_CNT_W'(csum_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pkt_r   <= '0;
      err_r   <= '0;
      csum_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pkt_r   <= pkt_nxt;
      err_r   <= err_nxt;
      csum_r  <= csum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_id_r <= frame_id_nxt;
    len_hi_r   <= len_hi_nxt;
    left_r     <= left_nxt;
    xor_r      <= xor_nxt;
    check_r    <= check_nxt;
  end

endmodule

/* src/stx_obuf.sv */
// Two-entry result buffer between the parser and the output channel
module stx_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stx_pkg::result_t  push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output stx_pkg::result_t  out_data
);
  import stx_pkg::*;

  result_t     mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        pop;

  assign has_room  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/stx_etx_xor_frame_receiver_top.sv */
// STX/ETX framed receiver with XOR check byte: top level
// Each result beat is registered in the result buffer and leaves on out_tvalid in arrival order.
// Throughput: one input byte per cycle while in_tready is high; the parser updates all state on each accepted byte.
// A two-entry result buffer keeps input flowing while a result waits; in_tready drops when full.
// Reset (rst_n low, synchronous): hunt for start byte, counters zero, buffer empty,
// max_length 255, wanted_app_id 0.
module stx_etx_xor_frame_receiver_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] rx_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [103:0]              out_tdata,  // [7:0] out_byte, [39:8] packet_total,
                                                // [71:40] error_total,
                                                // [103:72] checksum_error_total
  output logic [1:0]                out_tuser,  // [1:0] out_kind
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [stx_pkg::LEN_W-1:0] cfg_data
);
  import stx_pkg::*;

  `include "stx_etx_xor_frame_receiver_top_macros.svh"

  logic [LEN_W-1:0] max_len_r;
  logic [7:0]       app_id_r;
  logic             in_fire;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      app_id_r  <= APP_ID_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_LEN: max_len_r <= cfg_data;
        REG_APP_ID:  app_id_r  <= cfg_data[7:0];
      endcase
    end
  end

  stx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .rx_byte   (in_tdata),
    .max_len   (max_len_r),
    .app_id    (app_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  stx_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_room  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {out_res.csum_err_total, out_res.err_total,
                      out_res.pkt_total, out_res.data};

  `STX_ASSERT_NOW(a_full_means_valid, !in_tready, out_tvalid, "buffer full without output")
  `STX_ASSERT_NOW(a_status_byte_zero, out_tvalid && (out_tuser != KIND_PAYLOAD),
                  out_tdata[7:0] == 8'h00, "status beat carries nonzero byte")
  `STX_ASSERT_NOW(a_err_covers_csum, out_tvalid,
                  out_tdata[71:40] >= out_tdata[103:72], "checksum errors exceed errors")
  `STX_ASSERT_NEXT(a_result_shows, in_fire && !out_tvalid && res_valid,
                   out_tvalid, "result not presented")

endmodule

/* tb/sv/tb_stx_etx_xor_frame_receiver_top.sv */
// Self-checking testbench for the STX/ETX XOR-checked frame receiver top level
module tb_stx_etx_xor_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stx_pkg::*;

  localparam int ITEMS = 1450;

  typedef enum logic [2:0] {
    HUNT, GET_ID, GET_LEN_HI, GET_LEN_LO, GET_PAYLOAD, GET_CHECK, GET_ETX
  } parse_phase_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = REG_MAX_LEN;
  logic [LEN_W-1:0] cfg_data = '0;

  stx_etx_xor_frame_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // frame parser shadow state
  logic [LEN_W-1:0] max_len_cfg = MAX_LEN_RESET;
  logic [7:0]       app_id_cfg = APP_ID_RESET;
  parse_phase_t     rx_phase = HUNT;
  logic [7:0]       frame_id = 8'h00;
  logic [4:0]       len_high = 5'h00;
  logic [LEN_W-1:0] bytes_left = '0;
  logic [7:0]       running_xor = 8'h00;
  logic [7:0]       check_byte = 8'h00;
  logic [31:0]      packet_cnt = '0;
  logic [31:0]      error_cnt = '0;
  logic [31:0]      csum_error_cnt = '0;

  result_t results_due[$];
  int      fail_count = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;

  function automatic logic [31:0] bump_sat(input logic [31:0] c);
    return (&c) ? c : c + 32'd1;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [7:0] d);
    result_t r;
    r.kind = k;
    r.data = d;
    r.pkt_total = packet_cnt;
    r.err_total = error_cnt;
    r.csum_err_total = csum_error_cnt;
    results_due.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [LEN_W-1:0] flen;
    case (rx_phase)
      GET_ID: begin
        frame_id = b;
        running_xor = b;
        rx_phase = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        len_high = b[4:0] & LEN_HIGH_MASK;
        running_xor ^= b;
        rx_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        running_xor ^= b;
        flen = {len_high, b};
        if (flen > max_len_cfg) begin
          rx_phase = HUNT;
        end else begin
          packet_cnt = bump_sat(packet_cnt);
          if (frame_id != app_id_cfg) begin
            rx_phase = HUNT;
          end else begin
            bytes_left = flen;
            rx_phase = (flen == '0) ? GET_CHECK : GET_PAYLOAD;
          end
        end
      end
      GET_PAYLOAD: begin
        running_xor ^= b;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) rx_phase = GET_CHECK;
        queue_result(KIND_PAYLOAD, b);
      end
      GET_CHECK: begin
        check_byte = b;
        rx_phase = GET_ETX;
      end
      GET_ETX: begin
        rx_phase = HUNT;
        if (b != ETX_BYTE) begin
          error_cnt = bump_sat(error_cnt);
          queue_result(KIND_ETX_ERR, 8'h00);
        end else if (running_xor != check_byte) begin
          error_cnt = bump_sat(error_cnt);
          csum_error_cnt = bump_sat(csum_error_cnt);
          queue_result(KIND_CSUM_ERR, 8'h00);
        end else begin
          queue_result(KIND_GOOD, 8'h00);
        end
      end
      default: rx_phase = (b == STX_BYTE) ? GET_ID : HUNT;
    endcase
  endfunction

  // result checking
  result_t got, want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser};
      if (results_due.size() == 0) begin
        $error("unexpected result beat: kind %0d byte %02h", out_tuser, got.data);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
          fail_count++;
        end
        if (got.data !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, got.data);
          fail_count++;
        end
        if (got.pkt_total !== want.pkt_total) begin
          $error("packet_total: expected %0d, got %0d", want.pkt_total, got.pkt_total);
          fail_count++;
        end
        if (got.err_total !== want.err_total) begin
          $error("error_total: expected %0d, got %0d", want.err_total, got.err_total);
          fail_count++;
        end
        if (got.csum_err_total !== want.csum_err_total) begin
          $error("checksum_error_total: expected %0d, got %0d",
                 want.csum_err_total, got.csum_err_total);
          fail_count++;
        end
      end
    end
  end

  // receiver backpressure
  int ready_pct = 100;
  int ready_hold = 0;

  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
      ready_hold = $urandom_range(20, 120);
    end else begin
      ready_hold--;
    end
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    parse_byte(b);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MAX_LEN) max_len_cfg = val;
    else app_id_cfg = val[7:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_app_id(input logic [7:0] id);
    write_reg(REG_APP_ID, {5'($urandom), id});
  endtask

  function automatic int cap_len(input int lim);
    return (int'(max_len_cfg) < lim) ? int'(max_len_cfg) : lim;
  endfunction

  task automatic send_header(input logic [7:0] id, input int len);
    logic [LEN_W-1:0] l13;
    l13 = LEN_W'(len);
    send_byte(STX_BYTE);
    send_byte(id);
    send_byte({3'($urandom), l13[12:8]});
    send_byte(l13[7:0]);
  endtask

  task automatic send_frame(input logic [7:0] id, input int len,
                            input bit bad_sum, input bit bad_etx);
    logic [LEN_W-1:0] l13;
    logic [7:0] hi, x, b, term;
    l13 = LEN_W'(len);
    hi = {3'($urandom), l13[12:8]};
    x = id ^ hi ^ l13[7:0];
    send_byte(STX_BYTE);
    send_byte(id);
    send_byte(hi);
    send_byte(l13[7:0]);
    repeat (len) begin
      b = 8'($urandom);
      x ^= b;
      send_byte(b);
    end
    if (bad_sum) x ^= 8'($urandom_range(1, 255));
    send_byte(x);
    term = ETX_BYTE;
    if (bad_etx) begin
      term = 8'($urandom);
      while (term == ETX_BYTE) term = 8'($urandom);
    end
    send_byte(term);
  endtask

  task automatic test_reset_frames();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_frame(APP_ID_RESET, 0, 1'b0, 1'b0);
    send_frame(APP_ID_RESET, 1, 1'b1, 1'b0);
    send_frame(APP_ID_RESET, 0, 1'b0, 1'b1);
    send_header(8'h07, 5);
    send_header(APP_ID_RESET, 256);
  endtask

  task automatic test_length_limits();
    write_reg(REG_MAX_LEN, 13'd0);
    set_app_id(8'hFF);
    send_frame(8'hFF, 0, 1'b0, 1'b0);
    send_header(8'hFF, 1);
    write_reg(REG_MAX_LEN, 13'h1FFF);
    set_app_id(8'h00);
    send_header(8'h01, 8191);
    send_frame(8'h00, 3, 1'b0, 1'b0);
    write_reg(REG_MAX_LEN, 13'h1FFE);
    send_header(8'h00, 8191);
    write_reg(REG_MAX_LEN, 13'd20);
    set_app_id(8'hA5);
    send_frame(8'hA5, 20, 1'b0, 1'b0);
    send_header(8'hA5, 21);
  endtask

  task automatic run_traffic(input int chunk_bytes);
    int stop_at, pick, n;
    stop_at = bytes_sent + chunk_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, cap_len(120))
                                         : $urandom_range(0, cap_len(12));
        send_frame(app_id_cfg, n, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      end else if (pick < 70) begin
        send_header(app_id_cfg ^ 8'($urandom_range(1, 255)),
                    $urandom_range(0, cap_len(8191)));
      end else if (pick < 80 && max_len_cfg != 13'h1FFF) begin
        send_header(8'($urandom), $urandom_range(int'(max_len_cfg) + 1, 8191));
      end else if (pick < 88) begin
        send_byte(STX_BYTE);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    int chunk;
    for (chunk = 0; chunk < 4; chunk++) begin
      write_reg(REG_MAX_LEN, (chunk == 3) ? MAX_LEN_RESET : 13'($urandom_range(0, 40)));
      set_app_id(8'($urandom));
      while (bytes_sent < ITEMS * (chunk + 1) / 4) begin
        run_traffic(120);
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_frames();
    test_length_limits();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* stx_etx_xor_frame_receiver_top.f */
+incdir+src
src/stx_pkg.sv
src/stx_parser.sv
src/stx_obuf.sv
src/stx_etx_xor_frame_receiver_top.sv
tb/sv/tb_stx_etx_xor_frame_receiver_top.sv
